FILE: sv/csfp_pkg.sv
// ----------------------------------------------------------------------------
// csfp_pkg
// shared types and codes for the custody signal fill parser
// ----------------------------------------------------------------------------
package csfp_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_FILL   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_FRAGMENT  = 2'd0;
   localparam logic [1:0] ERR_TRUNCATED = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

   // one payload word as taken from the request channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       is_fragment;
   } req_word_type;

   // one result word
   typedef struct packed {
      logic [1:0]  result_kind;
      logic        succeeded;
      logic [6:0]  reason_code;
      logic [31:0] fill_start;
      logic [31:0] fill_length;
      logic [1:0]  error_code;
      logic        end_of_signal;
   } rsp_word_type;

endpackage

FILE: sv/csfp_input_reg.sv
// ----------------------------------------------------------------------------
// csfp_input_reg
// input register holding one request word until the decoder consumes it
// ----------------------------------------------------------------------------
module csfp_input_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csfp_pkg::req_word_type req_word,
   input  logic                  consume,
   output logic                  word_valid,
   output csfp_pkg::req_word_type word
);

   logic                   valid_ff;
   logic                   valid_in;
   csfp_pkg::req_word_type word_ff;
   logic                   take;

   assign req_ready  = !valid_ff || consume;
   assign take       = req_valid && req_ready;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_word;
      end
   end

endmodule

FILE: sv/csfp_decode.sv
// ----------------------------------------------------------------------------
// csfp_decode
// status byte and sdnv pair decoding, one word per cycle while fire is asserted
// ----------------------------------------------------------------------------
module csfp_decode #(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  csfp_pkg::req_word_type word,
   output logic                   emit,
   output csfp_pkg::rsp_word_type result
);

   localparam logic [1:0] PH_STATUS = 2'd0;
   localparam logic [1:0] PH_START  = 2'd1;
   localparam logic [1:0] PH_LENGTH = 2'd2;

   logic [1:0]            phase_ff,   phase_in;
   logic [VALUE_BITS-1:0] acc_ff,     acc_in;
   logic [VALUE_BITS-1:0] held_ff,    held_in;
   logic [VALUE_BITS-1:0] prev_ff,    prev_in;
   logic                  have_ff,    have_in;
   logic                  discard_ff, discard_in;

   logic [VALUE_BITS-1:0] acc_next;
   logic [VALUE_BITS-1:0] start_abs;
   logic [VALUE_BITS-1:0] fill_end;
   logic                  overflow;
   logic [VALUE_BITS+31:0] start_wide;
   logic [VALUE_BITS+31:0] len_wide;

   // any of the top seven bits set means one more byte would not fit
   assign overflow  = |acc_ff[VALUE_BITS-1:VALUE_BITS-7];
   assign acc_next  = {acc_ff[VALUE_BITS-8:0], word.data_byte[6:0]};
   assign start_abs = have_ff ? (acc_next + prev_ff) : acc_next;
   assign fill_end  = held_ff + acc_next - {{(VALUE_BITS-1){1'b0}}, 1'b1};
   assign start_wide = {32'd0, held_ff};
   assign len_wide   = {32'd0, acc_next};

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      held_in    = held_ff;
      prev_in    = prev_ff;
      have_in    = have_ff;
      discard_in = discard_ff;
      emit       = 1'b0;
      result     = '0;
      if (fire) begin
         if (word.first_byte) begin
            // new signal: drop whatever was in flight
            acc_in     = '0;
            held_in    = '0;
            prev_in    = '0;
            have_in    = 1'b0;
            discard_in = 1'b0;
            phase_in   = PH_STATUS;
            emit       = 1'b1;
            if (word.is_fragment) begin
               result.result_kind   = csfp_pkg::KIND_ERROR;
               result.error_code    = csfp_pkg::ERR_FRAGMENT;
               result.end_of_signal = 1'b1;
               discard_in           = !word.last_byte;
            end else begin
               result.result_kind   = csfp_pkg::KIND_HEADER;
               result.succeeded     = word.data_byte[7];
               result.reason_code   = word.data_byte[6:0];
               result.end_of_signal = word.last_byte;
               phase_in             = word.last_byte ? PH_STATUS : PH_START;
            end
         end else if (discard_ff || phase_ff == PH_STATUS) begin
            if (word.last_byte) begin
               discard_in = 1'b0;
            end
         end else if (overflow) begin
            emit                 = 1'b1;
            result.result_kind   = csfp_pkg::KIND_ERROR;
            result.error_code    = csfp_pkg::ERR_OVERFLOW;
            result.end_of_signal = word.last_byte;
            acc_in               = '0;
            discard_in           = !word.last_byte;
            phase_in             = PH_STATUS;
         end else if (word.data_byte[7]) begin
            acc_in = acc_next;
            if (word.last_byte) begin
               emit                 = 1'b1;
               result.result_kind   = csfp_pkg::KIND_ERROR;
               result.error_code    = csfp_pkg::ERR_TRUNCATED;
               result.end_of_signal = 1'b1;
               acc_in               = '0;
               phase_in             = PH_STATUS;
            end
         end else if (phase_ff == PH_START) begin
            held_in = start_abs;
            acc_in  = '0;
            if (word.last_byte) begin
               emit                 = 1'b1;
               result.result_kind   = csfp_pkg::KIND_ERROR;
               result.error_code    = csfp_pkg::ERR_TRUNCATED;
               result.end_of_signal = 1'b1;
               phase_in             = PH_STATUS;
            end else begin
               phase_in = PH_LENGTH;
            end
         end else begin
            // length complete
            emit                 = 1'b1;
            result.result_kind   = csfp_pkg::KIND_FILL;
            result.fill_start    = start_wide[31:0];
            result.fill_length   = len_wide[31:0];
            result.end_of_signal = word.last_byte;
            prev_in              = fill_end;
            have_in              = 1'b1;
            acc_in               = '0;
            phase_in             = word.last_byte ? PH_STATUS : PH_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STATUS;
         acc_ff     <= '0;
         held_ff    <= '0;
         prev_ff    <= '0;
         have_ff    <= 1'b0;
         discard_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         held_ff    <= held_in;
         prev_ff    <= prev_in;
         have_ff    <= have_in;
         discard_ff <= discard_in;
      end
   end

endmodule

FILE: sv/csfp_output_reg.sv
// ----------------------------------------------------------------------------
// csfp_output_reg
// result register toward the response channel
// ----------------------------------------------------------------------------
module csfp_output_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  csfp_pkg::rsp_word_type load_word,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output csfp_pkg::rsp_word_type rsp_word
);

   logic                   valid_ff;
   logic                   valid_in;
   csfp_pkg::rsp_word_type word_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule

FILE: sv/custody_signal_fill_parser.sv
// ----------------------------------------------------------------------------
// custody_signal_fill_parser
// aggregate custody signal payload parser: status header and sdnv fill pairs
// ----------------------------------------------------------------------------
// a word accepted into the input register is decoded from there, and any result it
// gives is registered in the output register, from which the response channel takes it
// throughput: one word per cycle while the output register is free, set by the registered
// state update in the decoder; while a result waits in the output register the decoder
// stalls, and the input register holds one more word and then drops ready
// reset: synchronous, active high; clears both valid flags and all decoder state
// ----------------------------------------------------------------------------
module custody_signal_fill_parser #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel, one payload byte per word
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        req_is_fragment,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_succeeded,
   output logic [6:0]  rsp_reason_code,
   output logic [31:0] rsp_fill_start,
   output logic [31:0] rsp_fill_length,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_end_of_signal
);

   csfp_pkg::req_word_type req_word;
   csfp_pkg::req_word_type held_word;
   csfp_pkg::rsp_word_type dec_result;
   csfp_pkg::rsp_word_type out_word;
   logic                   held_valid;
   logic                   out_free;
   logic                   fire;
   logic                   emit;

   // pack the request ports into one word
   assign req_word.data_byte   = req_data_byte;
   assign req_word.first_byte  = req_first_byte;
   assign req_word.last_byte   = req_last_byte;
   assign req_word.is_fragment = req_is_fragment;

   // the decoder steps whenever a word is held and the result slot can take
   // a result, so no word is decoded without room for what it produces
   assign fire = held_valid && out_free;

   // stage 1: input register
   csfp_input_reg u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .consume    (fire),
      .word_valid (held_valid),
      .word       (held_word)
   );

   // stage 2: combinational decode and registered state update
   csfp_decode #(
      .VALUE_BITS (VALUE_BITS)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .word   (held_word),
      .emit   (emit),
      .result (dec_result)
   );

   // result register; a word that gives no result leaves it untouched
   csfp_output_reg u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_word (dec_result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (out_word)
   );

   // unpack the result word onto the response ports
   assign rsp_result_kind   = out_word.result_kind;
   assign rsp_succeeded     = out_word.succeeded;
   assign rsp_reason_code   = out_word.reason_code;
   assign rsp_fill_start    = out_word.fill_start;
   assign rsp_fill_length   = out_word.fill_length;
   assign rsp_error_code    = out_word.error_code;
   assign rsp_end_of_signal = out_word.end_of_signal;

endmodule
